// File: rtl/assert_macros.svh
// Assertion macros, included by int_to_decimal_ascii, the one RTL file that carries checks.
// Depends on nothing; every macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// File: rtl/itda_pkg.sv
// Package for the integer to decimal ASCII converter: widths, character codes and types.
// Depends on nothing; used by itda_dabble and int_to_decimal_ascii.
`default_nettype none

package itda_pkg;

    // Field widths and the size of the decimal register.
    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_W + 1);
    localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W     = 8;

    // Character codes and the mode code.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic              OP_SIGNED  = 1'b0;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_STRIP,
        ST_SIGN,
        ST_DIGITS
    } itda_state_t;

    // Commands from the controller to the conversion core.
    typedef struct packed {
        logic load;
        logic shift_digit;
    } itda_ctrl_t;

    // Status from the conversion core back to the controller.
    typedef struct packed {
        logic       busy;
        logic [3:0] top_digit;
    } itda_status_t;

endpackage

`default_nettype wire

// File: rtl/int_to_decimal_ascii.sv
// After a transaction is accepted, the value is converted, leading zeros are dropped (one digit
// is always kept), then one character a cycle (1 to 11 characters) is sent while taken.
// One value is handled at a time: a new one is accepted only once its last character is loaded;
// conversion runs in the bit-serial double-dabble loop in itda_dabble (one bit a cycle).
// Reset: aresetn is synchronous, active low, and returns the block to idle with no output.
`default_nettype none
`include "assert_macros.svh"

module int_to_decimal_ascii (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_op,
    input  wire logic [itda_pkg::VALUE_W-1:0]  s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [itda_pkg::CHAR_W-1:0]        m_character,
    output logic                               m_last
);
    import itda_pkg::*;

    itda_state_t        state_reg, state_next;
    itda_ctrl_t         ctrl;
    itda_status_t       status;
    logic [VALUE_W-1:0] mag;
    logic               neg_reg, neg_next;
    logic [NDIG_W-1:0]  ndig_reg, ndig_next;
    logic               m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]  m_character_reg, m_character_next;
    logic               m_last_reg, m_last_next;
    logic               in_neg;
    logic               out_free;
    logic               strip_more;
    logic               load_minus;
    logic               load_digit;

    // The sign is taken from the input; the magnitude is formed in 32 unsigned bits.
    assign in_neg     = (s_op == OP_SIGNED) && s_value[VALUE_W-1];
    assign mag        = in_neg ? (VALUE_W'(0) - s_value) : s_value;
    assign out_free   = !m_valid_reg || m_ready;
    assign strip_more = (status.top_digit == 4'd0) && (ndig_reg > NDIG_W'(1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CONVERT;
            end
            ST_CONVERT: begin
                if (!status.busy) state_next = ST_STRIP;
            end
            ST_STRIP: begin
                if (!strip_more) state_next = neg_reg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                if (out_free) state_next = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (out_free && (ndig_reg == NDIG_W'(1))) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        s_ready          = 1'b0;
        ctrl.load        = 1'b0;
        ctrl.shift_digit = 1'b0;
        load_minus       = 1'b0;
        load_digit       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                ctrl.load = s_valid;
            end
            ST_CONVERT: begin
            end
            ST_STRIP: begin
                ctrl.shift_digit = strip_more;
            end
            ST_SIGN: begin
                load_minus = out_free;
            end
            ST_DIGITS: begin
                load_digit       = out_free;
                ctrl.shift_digit = out_free;
            end
            default: begin
            end
        endcase
    end

    // Digit count, sign and output register.
    always_comb begin
        neg_next         = neg_reg;
        ndig_next        = ndig_reg;
        m_character_next = m_character_reg;
        m_last_next      = m_last_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        if (ctrl.load) begin
            neg_next  = in_neg;
            ndig_next = NDIG_W'(NUM_DIGITS);
        end else if (ctrl.shift_digit) begin
            ndig_next = ndig_reg - NDIG_W'(1);
        end
        priority if (load_minus) begin
            m_character_next = CHAR_MINUS;
            m_last_next      = 1'b0;
            m_valid_next     = 1'b1;
        end else if (load_digit) begin
            m_character_next = CHAR_ZERO + CHAR_W'(status.top_digit);
            m_last_next      = (ndig_reg == NDIG_W'(1));
            m_valid_next     = 1'b1;
        end else begin
            // No new character: the output register keeps its contents.
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ndig_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ndig_reg    <= ndig_next;
            m_valid_reg <= m_valid_next;
        end
        neg_reg         <= neg_next;
        m_character_reg <= m_character_next;
        m_last_reg      <= m_last_next;
    end

    // Conversion core.
    itda_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .mag     (mag),
        .status  (status)
    );

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

    // The core only converts while the controller waits for it.
    `ASSERT_CLK(a_busy_in_convert, status.busy |-> (state_reg == ST_CONVERT), "core busy outside conversion")
    // A character that is not the last one can only wait while the text is still being sent.
    `ASSERT_CLK(a_mid_text, (m_valid_reg && !m_last_reg) |-> ((state_reg == ST_SIGN) || (state_reg == ST_DIGITS)), "text cut short")
    // Stripping and sending always keep at least one digit in hand.
    `ASSERT_NEVER(a_no_digits, ((state_reg == ST_STRIP) || (state_reg == ST_DIGITS)) && (ndig_reg == '0), "digit count ran out")

endmodule

`default_nettype wire

// File: rtl/itda_dabble.sv
// Bit-serial double-dabble core: shifts a 32-bit magnitude into ten BCD digits, one bit a cycle,
// then hands the digits out most significant first. Depends on itda_pkg.
`default_nettype none

module itda_dabble (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire itda_pkg::itda_ctrl_t          ctrl,
    input  wire logic [itda_pkg::VALUE_W-1:0]  mag,
    output itda_pkg::itda_status_t             status
);
    import itda_pkg::*;

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;

    // Add three to every digit of five or more before the next shift.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Next values: load a new magnitude, shift one bit in, or shift one digit out.
    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        priority if (ctrl.load) begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = CNT_W'(VALUE_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bin_next  = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next  = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end else if (ctrl.shift_digit) begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
        end else begin
            // Nothing to do: every register keeps its value.
        end
    end

    // Control state is reset; the data registers are loaded before use.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign status.busy      = busy_reg;
    assign status.top_digit = bcd_reg[BCD_W-1 -: 4];

endmodule

`default_nettype wire
